FILE: hw/rtl/wtbd_pkg.sv
// ----------------------------------------------------------------------------
// wtbd_pkg
// Shared types, codes and helpers of the weighted time-bin deposit block.
// ----------------------------------------------------------------------------
package wtbd_pkg;

	// Item modes
	localparam logic [1:0] MODE_CLEAR   = 2'd0;
	localparam logic [1:0] MODE_DEPOSIT = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;
	localparam logic [1:0] MODE_NOP     = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_TIME_ORIGIN  = 3'd0;
	localparam logic [2:0] REG_BIN_WIDTH    = 3'd1;
	localparam logic [2:0] REG_BINS_IN_USE  = 3'd2;
	localparam logic [2:0] REG_OFFSET_X     = 3'd3;
	localparam logic [2:0] REG_OFFSET_Y     = 3'd4;
	localparam logic [2:0] REG_X_POWER      = 3'd5;
	localparam logic [2:0] REG_Y_POWER      = 3'd6;
	localparam logic [2:0] REG_REF_MOMENTUM = 3'd7;

	// Iterative unit widths
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 32;
	localparam int SQRT_W  = 64;
	localparam int ROOT_W  = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_START,
		ST_WAIT_BIN,
		ST_WAIT_PZ,
		ST_DRIVE,
		ST_RD,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [47:0] sx;
		logic signed [47:0] sy;
	} sums_t;

	// 48-bit signed add with saturation
	function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
			input logic signed [23:0] b);
		logic signed [48:0] s;
		s = {a[47], a} + {{25{b[23]}}, b};
		if (s[48] != s[47]) begin
			return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
		return s[47:0];
	endfunction

endpackage

FILE: hw/rtl/wtbd_div.sv
// ----------------------------------------------------------------------------
// wtbd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtbd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wtbd_pkg::DIV_N_W-1:0]   dividend,
	input  logic [wtbd_pkg::DIV_D_W-1:0]   divisor,
	output logic                           busy,
	output logic [wtbd_pkg::DIV_N_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(wtbd_pkg::DIV_N_W);

	logic [wtbd_pkg::DIV_D_W-1:0] rem_q;
	logic [wtbd_pkg::DIV_D_W-1:0] dvs_q;
	logic [wtbd_pkg::DIV_N_W-1:0] quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic [wtbd_pkg::DIV_D_W:0]   rem_sh;
	logic [wtbd_pkg::DIV_D_W:0]   rem_sub;
	logic                         fits;

	assign rem_sh  = {rem_q, quo_q[wtbd_pkg::DIV_N_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(wtbd_pkg::DIV_N_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[wtbd_pkg::DIV_D_W-1:0] : rem_sh[wtbd_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[wtbd_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/wtbd_sqrt.sv
// ----------------------------------------------------------------------------
// wtbd_sqrt
// Integer square root, one result bit per cycle (digit-by-digit method).
// ----------------------------------------------------------------------------
module wtbd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wtbd_pkg::SQRT_W-1:0]   radicand,
	output logic                          busy,
	output logic [wtbd_pkg::ROOT_W-1:0]   root
);

	logic [wtbd_pkg::SQRT_W-1:0] v_q;
	logic [wtbd_pkg::SQRT_W-1:0] res_q;
	logic [wtbd_pkg::SQRT_W-1:0] bit_q;
	logic                        busy_q;
	logic [wtbd_pkg::SQRT_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(wtbd_pkg::SQRT_W-2){1'b0}}};
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[wtbd_pkg::ROOT_W-1:0];

endmodule

FILE: hw/rtl/weighted_time_bin_deposit.sv
// ----------------------------------------------------------------------------
// weighted_time_bin_deposit
// Time-binned histogram of particle drive terms with momentum readout.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) takes one item per transfer; mode selects
//  clear, deposit, read or no-op. Output channel (out_valid/out_ready) returns
//  exactly one result per item, in order. Configuration is a plain write port
//  (wr_en, wr_index, wr_data), which the user writes only while the block is
//  idle; the block does not enforce this. Steps per item, input to result:
//   deposit  prep, start, bin divide (root in parallel), momentum divide, then
//            the result when not binned; when binned the drive steps and the
//            read-modify-write come before the result.
//   read     memory read, then result;  no-op result;  clear all NUM_BINS entries.
//  The deposit time is set by the shared bit-serial divider, used once for
//  the bin index and once for pz; the sums live in one NUM_BINS x 96 bit
//  memory with a registered read, updated by read-modify-write.
//  One item is in work at a time; a finished result sits in the output
//  register, so the next item is taken while the receiver stalls. A second
//  result waits in the block until the output register frees up.
//  Reset: config registers take their defaults, then a clearing pass writes
//  zero to all NUM_BINS entries with in_ready low.
// ----------------------------------------------------------------------------
module weighted_time_bin_deposit #(
	parameter int NUM_BINS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [31:0] arrival_time,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] slope_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] slope_y,
	input  logic signed [23:0] momentum_dev,
	input  logic [9:0]         read_bin,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_binned,
	output logic [9:0]         bin_index,
	output logic [39:0]        long_momentum,
	output logic signed [47:0] sum_x_out,
	output logic signed [47:0] sum_y_out,
	output logic [31:0]        binned_total
);

	localparam int IDX_W = $clog2(NUM_BINS);

	// ---------------- configuration registers ----------------
	logic signed [31:0] origin_q;
	logic [30:0]        width_q;
	logic [10:0]        bins_q;
	logic signed [15:0] offx_q;
	logic signed [15:0] offy_q;
	logic [2:0]         xpow_q;
	logic [2:0]         ypow_q;
	logic [31:0]        pref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			width_q  <= 31'd1;
			bins_q   <= 11'd1024;
			offx_q   <= '0;
			offy_q   <= '0;
			xpow_q   <= 3'd1;
			ypow_q   <= 3'd1;
			pref_q   <= 32'd65536;
		end else if (wr_en) begin
			unique case (wr_index)
				wtbd_pkg::REG_TIME_ORIGIN:  origin_q <= wr_data;
				wtbd_pkg::REG_BIN_WIDTH:    width_q  <= wr_data[30:0];
				wtbd_pkg::REG_BINS_IN_USE:  bins_q   <= wr_data[10:0];
				wtbd_pkg::REG_OFFSET_X:     offx_q   <= wr_data[15:0];
				wtbd_pkg::REG_OFFSET_Y:     offy_q   <= wr_data[15:0];
				wtbd_pkg::REG_X_POWER:      xpow_q   <= wr_data[2:0];
				wtbd_pkg::REG_Y_POWER:      ypow_q   <= wr_data[2:0];
				wtbd_pkg::REG_REF_MOMENTUM: pref_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- control state ----------------
	wtbd_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0] clr_q;       // clearing sweep address
	logic             clr_rep_q;   // clear came from an item, not reset
	logic [2:0]       k_q;         // drive power step
	logic [31:0]      cnt_q;       // binned particle counter
	logic             out_valid_q;

	// item fields
	logic [1:0]         mode_q;
	logic signed [31:0] t_q;
	logic signed [15:0] px_q, xs_q, py_q, ys_q;
	logic signed [23:0] dv_q;

	// prep results
	logic        n_neg_q;
	logic [34:0] nmag_q;
	logic [31:0] w2_q;
	logic [55:0] num_q;
	logic [31:0] s_q;
	logic        fac_pos_q;
	logic signed [16:0] dx_q, dy_q;
	logic [34:0] qbin_q;

	// drive and memory
	logic signed [23:0] rx_q, ry_q;
	logic [IDX_W-1:0]   addr_q;
	wtbd_pkg::sums_t    rd_q;

	// pending result
	logic               res_binned_q;
	logic [9:0]         res_idx_q;
	logic [39:0]        res_pz_q;
	logic signed [47:0] res_sx_q, res_sy_q;

	// output register
	logic               o_binned_q;
	logic [9:0]         o_idx_q;
	logic [39:0]        o_pz_q;
	logic signed [47:0] o_sx_q, o_sy_q;
	logic [31:0]        o_total_q;

	// ---------------- arithmetic units ----------------
	logic                          div_start, div_busy;
	logic [wtbd_pkg::DIV_N_W-1:0]  div_n, div_quot;
	logic [wtbd_pkg::DIV_D_W-1:0]  div_d;
	logic                          sqrt_start, sqrt_busy;
	logic [wtbd_pkg::ROOT_W-1:0]   sqrt_root;

	wtbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	wtbd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({s_q, 30'd0}),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// ---------------- combinational helpers ----------------
	logic        accept;
	logic        out_free;
	logic        drive_done;
	logic        binned;
	logic [31:0] nb_eff;
	logic [31:0] rb_ext;
	logic        rb_ok;

	logic signed [32:0] t_diff;
	logic signed [34:0] n_val;
	logic [30:0]        w_eff;
	logic signed [24:0] fac;
	logic signed [31:0] xs_sq, ys_sq;
	logic signed [40:0] prod_x, prod_y;
	logic signed [23:0] term_x, term_y;
	logic signed [47:0] new_sx, new_sy;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign w_eff  = (width_q == '0) ? 31'd1 : width_q;
	assign t_diff = {t_q[31], t_q} - {origin_q[31], origin_q};
	assign n_val  = {t_diff[32], t_diff, 1'b0} + {4'd0, w_eff};
	assign fac    = 25'sd4194304 + {dv_q[23], dv_q};
	assign xs_sq  = xs_q * xs_q;
	assign ys_sq  = ys_q * ys_q;

	assign prod_x = rx_q * dx_q;
	assign prod_y = ry_q * dy_q;
	assign drive_done = (k_q >= xpow_q) && (k_q >= ypow_q);

	// bins_in_use clamped to the memory depth
	assign nb_eff = ({21'd0, bins_q} > 32'(NUM_BINS)) ? 32'(NUM_BINS) : {21'd0, bins_q};
	// negative n rounds toward zero, so only a zero quotient is kept
	assign binned = (!n_neg_q || qbin_q == '0) && ({29'd0, qbin_q} < {32'd0, nb_eff});

	assign rb_ext = {22'd0, res_idx_q};
	assign rb_ok  = rb_ext < 32'(NUM_BINS);

	assign term_x = (xpow_q == '0) ? 24'sd32768 : rx_q;
	assign term_y = (ypow_q == '0) ? 24'sd32768 : ry_q;
	assign new_sx = wtbd_pkg::sat_add(rd_q.sx, term_x);
	assign new_sy = wtbd_pkg::sat_add(rd_q.sy, term_y);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wtbd_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						wtbd_pkg::MODE_CLEAR:   state_d = wtbd_pkg::ST_CLEAR;
						wtbd_pkg::MODE_DEPOSIT: state_d = wtbd_pkg::ST_PREP;
						wtbd_pkg::MODE_READ:    state_d = wtbd_pkg::ST_RD;
						default:                state_d = wtbd_pkg::ST_DONE;
					endcase
				end
			end
			wtbd_pkg::ST_CLEAR: begin
				if (clr_q == IDX_W'(NUM_BINS - 1)) begin
					state_d = clr_rep_q ? wtbd_pkg::ST_DONE : wtbd_pkg::ST_IDLE;
				end
			end
			wtbd_pkg::ST_PREP:  state_d = wtbd_pkg::ST_START;
			wtbd_pkg::ST_START: state_d = wtbd_pkg::ST_WAIT_BIN;
			wtbd_pkg::ST_WAIT_BIN: begin
				if (!div_busy && !sqrt_busy) begin
					state_d = wtbd_pkg::ST_WAIT_PZ;
				end
			end
			wtbd_pkg::ST_WAIT_PZ: begin
				if (!div_busy) begin
					state_d = binned ? wtbd_pkg::ST_DRIVE : wtbd_pkg::ST_DONE;
				end
			end
			wtbd_pkg::ST_DRIVE: begin
				if (drive_done) begin
					state_d = wtbd_pkg::ST_RD;
				end
			end
			wtbd_pkg::ST_RD:  state_d = wtbd_pkg::ST_MOD;
			wtbd_pkg::ST_MOD: state_d = wtbd_pkg::ST_DONE;
			wtbd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wtbd_pkg::ST_IDLE;
				end
			end
			default: state_d = wtbd_pkg::ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	wtbd_pkg::sums_t  mem_wdata;

	always_comb begin
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		div_n      = {29'd0, nmag_q};
		div_d      = w2_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = '{sx: new_sx, sy: new_sy};
		unique case (state_q)
			wtbd_pkg::ST_START: begin
				div_start  = 1'b1;
				sqrt_start = 1'b1;
			end
			wtbd_pkg::ST_WAIT_BIN: begin
				// momentum divide follows straight on with the fresh root
				div_start = !div_busy && !sqrt_busy;
				div_n     = {num_q, 8'd0};
				div_d     = sqrt_root;
			end
			wtbd_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			wtbd_pkg::ST_MOD: begin
				mem_we = (mode_q == wtbd_pkg::MODE_DEPOSIT);
			end
			default: ;
		endcase
	end

	// ---------------- bin sum memory ----------------
	wtbd_pkg::sums_t sums_mem [NUM_BINS];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == wtbd_pkg::ST_RD) begin
			rd_q <= sums_mem[addr_q];
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wtbd_pkg::ST_CLEAR;
			clr_q       <= '0;
			clr_rep_q   <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				clr_q     <= '0;
				clr_rep_q <= 1'b1;
			end else if (state_q == wtbd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				cnt_q <= '0;
			end
			if (state_q == wtbd_pkg::ST_WAIT_PZ) begin
				k_q <= 3'd1;
			end else if (state_q == wtbd_pkg::ST_DRIVE && !drive_done) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == wtbd_pkg::ST_MOD && mode_q == wtbd_pkg::MODE_DEPOSIT
					&& cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == wtbd_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q       <= mode;
			t_q          <= arrival_time;
			px_q         <= pos_x;
			xs_q         <= slope_x;
			py_q         <= pos_y;
			ys_q         <= slope_y;
			dv_q         <= momentum_dev;
			res_binned_q <= 1'b0;
			res_idx_q    <= (mode == wtbd_pkg::MODE_READ) ? read_bin : 10'd0;
			res_pz_q     <= '0;
			res_sx_q     <= '0;
			res_sy_q     <= '0;
			addr_q       <= IDX_W'({22'd0, read_bin});
		end

		unique case (state_q)
			wtbd_pkg::ST_PREP: begin
				n_neg_q   <= n_val[34];
				nmag_q    <= n_val[34] ? 35'(-n_val) : 35'(n_val);
				w2_q      <= {w_eff, 1'b0};
				num_q     <= pref_q * fac[23:0];
				fac_pos_q <= !fac[24] && (fac != '0);
				s_q       <= 32'd1073741824 + 32'(xs_sq) + 32'(ys_sq);
				dx_q      <= {px_q[15], px_q} - {offx_q[15], offx_q};
				dy_q      <= {py_q[15], py_q} - {offy_q[15], offy_q};
			end
			wtbd_pkg::ST_WAIT_BIN: begin
				if (!div_busy && !sqrt_busy) begin
					qbin_q <= div_quot[34:0];
				end
			end
			wtbd_pkg::ST_WAIT_PZ: begin
				if (!div_busy) begin
					res_pz_q     <= fac_pos_q ? div_quot[39:0] : 40'd0;
					res_binned_q <= binned;
					res_idx_q    <= binned ? qbin_q[9:0] : 10'd0;
					addr_q       <= qbin_q[IDX_W-1:0];
					rx_q         <= {{7{dx_q[16]}}, dx_q};
					ry_q         <= {{7{dy_q[16]}}, dy_q};
				end
			end
			wtbd_pkg::ST_DRIVE: begin
				// r = floor(r * d / 2^15), one step per cycle per axis
				if (k_q < xpow_q) begin
					rx_q <= prod_x[38:15];
				end
				if (k_q < ypow_q) begin
					ry_q <= prod_y[38:15];
				end
			end
			wtbd_pkg::ST_MOD: begin
				if (mode_q == wtbd_pkg::MODE_DEPOSIT) begin
					res_sx_q <= new_sx;
					res_sy_q <= new_sy;
				end else begin
					res_sx_q <= rb_ok ? rd_q.sx : 48'sd0;
					res_sy_q <= rb_ok ? rd_q.sy : 48'sd0;
				end
			end
			default: ;
		endcase

		if (state_q == wtbd_pkg::ST_DONE && out_free) begin
			o_binned_q <= res_binned_q;
			o_idx_q    <= res_idx_q;
			o_pz_q     <= res_pz_q;
			o_sx_q     <= res_sx_q;
			o_sy_q     <= res_sy_q;
			o_total_q  <= cnt_q;
		end
	end

	assign in_ready      = (state_q == wtbd_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign was_binned    = o_binned_q;
	assign bin_index     = o_idx_q;
	assign long_momentum = o_pz_q;
	assign sum_x_out     = o_sx_q;
	assign sum_y_out     = o_sy_q;
	assign binned_total  = o_total_q;

endmodule
